@@ src/mlle_pkg.sv @@
// package for the load level estimator
// types, register indexes, fixed constants and level map functions; no dependencies
`timescale 1ns / 1ps
package mlle_pkg;
  localparam int TIME_W = 48;
  localparam int LOAD_W = 15;
  localparam int BLINK_W = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TH_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TH_MED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TH_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd5;

  localparam logic [15:0] Q15_ONE = 16'd32768;
  localparam logic [14:0] BOUND_VERY_LOW = 15'd3277;
  localparam logic [14:0] BOUND_LOW = 15'd6554;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  typedef struct packed {
    logic [15:0] alpha;
    logic [14:0] th_low;
    logic [14:0] th_med;
    logic [14:0] th_high;
    logic [23:0] timeout;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;    // capture input word
    logic ring_write;   // write magnitude into ring
    logic ring_clear;   // clear one ring entry (sweep)
    logic sum_clear;
    logic sum_step;     // accumulate one ring entry / channel
    logic mean_write;
    logic expire_step;  // check timeout of channel at scan index
    logic div_start;
    logic div_step;
    logic mul_a;        // first ema product
    logic mul_b;        // second ema product and finish
    logic publish;      // latch result word
    logic rate_start;   // interval divide after rate write
  } cmd_t;

  typedef struct packed {
    logic is_eval;
    logic chan_ok;
    logic div_done;
    logic due;
  } stat_t;

  function automatic logic [2:0] level_of(input logic [14:0] v, input cfg_t c);
    if (v < BOUND_VERY_LOW) return 3'd0;
    if (v < BOUND_LOW) return 3'd1;
    if (v < c.th_low) return 3'd2;
    if (v < c.th_med) return 3'd3;
    if (v < c.th_high) return 3'd4;
    return 3'd5;
  endfunction

  function automatic logic [BLINK_W-1:0] blink_of(input logic [2:0] l);
    case (l)
      3'd0: return 21'd2000000;
      3'd1: return 21'd1000000;
      3'd2: return 21'd500000;
      3'd3: return 21'd200000;
      3'd4: return 21'd100000;
      default: return 21'd50000;
    endcase
  endfunction
endpackage

@@ src/mlle_if.sv @@
// valid/ready channel carrying one word of payload
// depends on nothing
`timescale 1ns / 1ps
interface mlle_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [2:0] channel;
  logic signed [15:0] duty;
  logic [47:0] now_us;
  modport source (output valid, func, channel, duty, now_us, input ready);
  modport sink (input valid, func, channel, duty, now_us, output ready);
endinterface

interface mlle_out_if;
  logic valid;
  logic ready;
  logic [2:0] level_code;
  logic [14:0] load_est;
  logic [20:0] blink_us;
  modport source (output valid, level_code, load_est, blink_us, input ready);
  modport sink (input valid, level_code, load_est, blink_us, output ready);
endinterface

@@ src/mlle_ctrl.sv @@
// sequencer for samples, evaluations, rate divides and the reset clear sweep
// depends on mlle_pkg
`timescale 1ns / 1ps
module mlle_ctrl #(
  parameter int CHANNELS = 8,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  input  logic cfg_rate_write,
  input  mlle_pkg::stat_t stat,
  output mlle_pkg::cmd_t cmd,
  output logic [$clog2(CHANNELS*HISTORY_DEPTH)-1:0] idx
);
  import mlle_pkg::*;
  localparam int ENTRIES = CHANNELS * HISTORY_DEPTH;
  localparam int IW = $clog2(ENTRIES);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DECODE = 4'd2,
    S_WRITE = 4'd3, S_SUM = 4'd4, S_MEAN = 4'd5, S_EXPIRE = 4'd6,
    S_ACC = 4'd7, S_DIV = 4'd8, S_MULA = 4'd9, S_MULB = 4'd10,
    S_PUB = 4'd11, S_RATE = 4'd12, S_SUMLAST = 4'd13, S_DIVGO = 4'd14;

  logic [3:0] state, state_next;
  logic [IW:0] count, count_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign idx = count[IW-1:0];
  assign in_ready = (state == S_IDLE) && !cfg_rate_write;

  // next state and commands
  always_comb begin
    cmd = '0;
    state_next = state;
    count_next = count;
    case (state)
      S_CLEAR: begin
        cmd.ring_clear = 1'b1;
        count_next = count + 1'b1;
        if (count == (IW+1)'(ENTRIES - 1)) begin
          state_next = S_IDLE;
          count_next = '0;
        end
      end
      S_IDLE: begin
        if (cfg_rate_write) begin
          cmd.rate_start = 1'b1;
          state_next = S_RATE;
        end else if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_RATE: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_IDLE;
      end
      S_DECODE: begin
        count_next = '0;
        cmd.sum_clear = 1'b1;
        if (stat.is_eval) state_next = S_EXPIRE;
        else if (stat.chan_ok) state_next = S_WRITE;
        else state_next = S_IDLE;
      end
      S_WRITE: begin
        cmd.ring_write = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        count_next = count + 1'b1;
        if (count == (IW+1)'(HISTORY_DEPTH - 1)) state_next = S_SUMLAST;
      end
      S_SUMLAST: begin
        cmd.sum_step = 1'b1;
        state_next = S_MEAN;
      end
      S_MEAN: begin
        cmd.mean_write = 1'b1;
        count_next = '0;
        state_next = S_IDLE;
      end
      S_EXPIRE: begin
        cmd.expire_step = 1'b1;
        count_next = count + 1'b1;
        if (count == (IW+1)'(CHANNELS - 1)) begin
          count_next = '0;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.sum_step = 1'b1;
        count_next = count + 1'b1;
        if (count == (IW+1)'(CHANNELS - 1)) begin
          count_next = '0;
          state_next = S_DIVGO;
        end
      end
      // divider loads once the last channel has been added
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_next = stat.due ? S_PUB : S_IDLE;
      end
      S_PUB: begin
        if (!out_busy) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ src/mlle_dp.sv @@
// datapath: ring memory, channel table, shared divider, ema and level map
// depends on mlle_pkg
`timescale 1ns / 1ps
module mlle_dp #(
  parameter int CHANNELS = 8,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  mlle_pkg::cmd_t cmd,
  output mlle_pkg::stat_t stat,
  input  logic [$clog2(CHANNELS*HISTORY_DEPTH)-1:0] idx,
  input  mlle_pkg::cfg_t cfg,
  input  logic [9:0] rate,
  input  logic in_func,
  input  logic [2:0] in_channel,
  input  logic [15:0] in_duty,
  input  logic [47:0] in_now,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] out_level,
  output logic [14:0] out_value,
  output logic [20:0] out_blink
);
  import mlle_pkg::*;
  localparam int ENTRIES = CHANNELS * HISTORY_DEPTH;
  localparam int IW = $clog2(ENTRIES);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUMW = 15 + $clog2(CHANNELS + 1) + HW;

  // captured word
  logic func;
  logic [2:0] chan;
  logic [14:0] mag;
  logic [47:0] now;
  logic [CW-1:0] ch;
  logic [15:0] neg;

  assign neg = 16'd0 - in_duty;
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func <= in_func;
      chan <= in_channel;
      now <= in_now;
      if (in_duty[15]) mag <= neg[15] ? 15'h7fff : neg[14:0];
      else mag <= in_duty[14:0];
    end
  end
  assign ch = chan[CW-1:0];
  assign stat.is_eval = func;
  assign stat.chan_ok = ({29'd0, chan} < 32'(CHANNELS));

  // ring memory and per channel pointers
  logic [14:0] ring [ENTRIES];
  logic [14:0] ring_q;
  logic [HW-1:0] ptr [CHANNELS];
  logic [IW-1:0] waddr, raddr;
  logic [IW-1:0] base;

  assign base = IW'(ch) << HW;
  assign waddr = base | IW'(ptr[ch]);
  assign raddr = base | IW'(idx[HW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.ring_clear) ring[idx] <= '0;
    else if (cmd.ring_write) ring[waddr] <= mag;
    ring_q <= ring[raddr];
  end

  // channel table
  logic [CHANNELS-1:0] active;
  logic [47:0] seen [CHANNELS];
  logic [14:0] mean [CHANNELS];
  logic [CW-1:0] scan;
  logic [47:0] age;
  logic [SUMW-1:0] sum;

  assign scan = idx[CW-1:0];
  assign age = now - seen[scan];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        ptr[i] <= '0;
        mean[i] <= '0;
        seen[i] <= '0;
      end
    end else begin
      if (cmd.ring_write) begin
        ptr[ch] <= (ptr[ch] == HW'(HISTORY_DEPTH - 1)) ? '0 : ptr[ch] + 1'b1;
        active[ch] <= 1'b1;
        seen[ch] <= now;
      end
      if (cmd.mean_write) mean[ch] <= 15'(sum >> HW);
      if (cmd.expire_step && active[scan] && (age > {24'd0, cfg.timeout})) begin
        active[scan] <= 1'b0;
        mean[scan] <= '0;
      end
    end
  end

  // accumulator: ring entries (added from the registered ring read) or active means
  logic [5:0] cnt;
  logic sum_first;
  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum <= '0;
      cnt <= '0;
      sum_first <= 1'b1;
    end else if (cmd.sum_step) begin
      sum_first <= 1'b0;
      if (func) begin
        if (active[scan]) begin
          sum <= sum + SUMW'(mean[scan]);
          cnt <= cnt + 1'b1;
        end
      end else if (!sum_first) begin
        sum <= sum + SUMW'(ring_q);
      end
    end
  end

  // shared restoring divider, one quotient bit a cycle
  localparam int DW = 20;
  logic [DW-1:0] dq, drem;
  logic [9:0] dden;
  logic [4:0] dbit;
  logic dbusy, dzero, drate;
  logic [DW:0] trial;
  logic [19:0] interval;
  assign trial = {drem[DW-2:0], dq[DW-1]} - {11'd0, dden};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      drate <= 1'b0;
      interval <= 20'd100000;
    end else if (cmd.rate_start) begin
      dq <= USEC_PER_SEC;
      drem <= '0;
      dden <= (rate == '0) ? 10'd1 : rate;
      dbit <= 5'(DW);
      dbusy <= 1'b1;
      dzero <= 1'b0;
      drate <= 1'b1;
    end else if (cmd.div_start) begin
      dq <= DW'(sum);
      drem <= '0;
      dden <= {4'd0, cnt};
      dbit <= 5'(DW);
      dbusy <= 1'b1;
      dzero <= (cnt == '0);
      drate <= 1'b0;
    end else if (cmd.div_step && dbusy) begin
      dbit <= dbit - 1'b1;
      if (!trial[DW]) begin
        drem <= trial[DW-1:0];
        dq <= {dq[DW-2:0], 1'b1};
      end else begin
        drem <= {drem[DW-2:0], dq[DW-1]};
        dq <= {dq[DW-2:0], 1'b0};
      end
      if (dbit == 5'd1) begin
        dbusy <= 1'b0;
        if (drate) interval <= trial[DW] ? {dq[DW-2:0], 1'b0} : {dq[DW-2:0], 1'b1};
      end
    end
  end
  assign stat.div_done = cmd.div_step && dbusy && (dbit == 5'd1);

  // ema in two products
  logic [15:0] alpha;
  logic [14:0] overall;
  logic [30:0] prod_a;
  logic [15:0] smooth;
  logic [31:0] mix;
  logic [47:0] last_pub;
  logic [47:0] since;
  assign alpha = (cfg.alpha > Q15_ONE) ? Q15_ONE : cfg.alpha;
  assign overall = dzero ? 15'd0 : dq[14:0];
  assign mix = {1'b0, prod_a} + (Q15_ONE - alpha) * smooth;
  assign since = now - last_pub;
  assign stat.due = (since >= {28'd0, interval});

  always_ff @(posedge clk) begin
    if (cmd.mul_a) prod_a <= 31'(alpha) * 31'(overall);
    if (rst) begin
      smooth <= '0;
      last_pub <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.mul_b) begin
        smooth <= mix[30:15];
        if (stat.due) last_pub <= now;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.publish) begin
        out_valid <= 1'b1;
        out_level <= level_of(smooth[14:0], cfg);
        out_value <= smooth[14:0];
        out_blink <= blink_of(level_of(smooth[14:0], cfg));
      end
    end
  end
endmodule

@@ src/multichannel_load_level_estimator_top.sv @@
// channel          | dir | payload
// in  (mlle_in_if) | in  | func, channel, duty, now_us
// out (mlle_out_if)| out | level_code, load_est, blink_us
// cfg              | in  | cfg_we, cfg_index, cfg_data
// a sample writes its channel's ring and sums it (ring read sweep); an evaluate
// runs two channel scans, the 20-step divider and the ema, and publishes when due
// a rate write occupies the divider until the new publish interval is set
// after reset the ring memory is cleared, one entry at a time
// an output word waits in its register; a stalled output holds the next publish
`timescale 1ns / 1ps
module multichannel_load_level_estimator_top #(
  parameter int CHANNELS = 8,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  mlle_in_if.sink in_ch,
  mlle_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [mlle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mlle_pkg::*;
  cfg_t cfg;
  logic [9:0] rate;
  cmd_t cmd;
  stat_t stat;
  logic [$clog2(CHANNELS*HISTORY_DEPTH)-1:0] idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha <= 16'd3277;
      cfg.th_low <= 15'd13107;
      cfg.th_med <= 15'd19661;
      cfg.th_high <= 15'd26214;
      cfg.timeout <= 24'd500000;
      rate <= 10'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA: cfg.alpha <= cfg_data[15:0];
        REG_TH_LOW: cfg.th_low <= cfg_data[14:0];
        REG_TH_MED: cfg.th_med <= cfg_data[14:0];
        REG_TH_HIGH: cfg.th_high <= cfg_data[14:0];
        REG_RATE: rate <= cfg_data[9:0];
        REG_TIMEOUT: cfg.timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // pending divide after a rate write
  logic rate_pend;
  always_ff @(posedge clk) begin
    if (rst) rate_pend <= 1'b0;
    else if (cfg_we && cfg_index == REG_RATE) rate_pend <= 1'b1;
    else if (cmd.rate_start) rate_pend <= 1'b0;
  end

  mlle_ctrl #(.CHANNELS(CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_busy(out_ch.valid),
    .cfg_rate_write(rate_pend),
    .stat, .cmd, .idx
  );

  mlle_dp #(.CHANNELS(CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat, .idx, .cfg, .rate,
    .in_func(in_ch.func),
    .in_channel(in_ch.channel),
    .in_duty(in_ch.duty),
    .in_now(in_ch.now_us),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_level(out_ch.level_code),
    .out_value(out_ch.load_est),
    .out_blink(out_ch.blink_us)
  );
endmodule

@@ src/mlle_checker.sv @@
// port checker for the load level estimator, bound to the top level
// uses no package; the bind needs the top level module
`timescale 1ns / 1ps
module mlle_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] level_code,
  input logic [14:0] load_est,
  input logic [20:0] blink_us
);
  // level stays within its range
  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_code <= 3'd5)) else $error("level out of range");
  // one word in flight: no input taken in the cycle after acceptance
  a_single: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  // blink follows level at the highest level code (5)
  a_blink: assert property (@(posedge clk) disable iff (rst)
    (out_valid && level_code == 3'd5) |-> (blink_us == 21'd50000))
    else $error("blink mismatch");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(load_est)))
    else $error("result dropped");
endmodule

bind multichannel_load_level_estimator_top mlle_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .level_code(out_ch.level_code), .load_est(out_ch.load_est),
  .blink_us(out_ch.blink_us)
);
